// File: hdl/piotrf_pkg.sv
package piotrf_pkg;

  // Item kinds
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_PINSA = 2'd2;
  localparam logic [1:0] MODE_PINSB = 2'd3;

  // Standard register map
  localparam logic [3:0] REG_ORB   = 4'd0;
  localparam logic [3:0] REG_ORA   = 4'd1;
  localparam logic [3:0] REG_DDRB  = 4'd2;
  localparam logic [3:0] REG_DDRA  = 4'd3;
  localparam logic [3:0] REG_T1CL  = 4'd4;
  localparam logic [3:0] REG_T1CH  = 4'd5;
  localparam logic [3:0] REG_T1LL  = 4'd6;
  localparam logic [3:0] REG_T1LH  = 4'd7;
  localparam logic [3:0] REG_T2CL  = 4'd8;
  localparam logic [3:0] REG_T2CH  = 4'd9;
  localparam logic [3:0] REG_SR    = 4'd10;
  localparam logic [3:0] REG_ACR   = 4'd11;
  localparam logic [3:0] REG_PCR   = 4'd12;
  localparam logic [3:0] REG_IFR   = 4'd13;
  localparam logic [3:0] REG_IER   = 4'd14;
  localparam logic [3:0] REG_ORANH = 4'd15;

  // Interrupt flag bits
  localparam logic [6:0] FLAG_T1 = 7'h40;
  localparam logic [6:0] FLAG_T2 = 7'h20;
  localparam logic [6:0] FLAG_SR = 7'h04;

  // ACR bits
  localparam int ACR_PB7_BIT   = 7;
  localparam int ACR_PULSE_BIT = 5;

  localparam logic [15:0] COUNT_ALL_ONES = 16'hFFFF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       port_a_notify;
    logic       port_b_notify;
  } res_t;

endpackage

// File: hdl/parallel_io_timer_register_file.sv
// Register file of a 6522-style parallel I/O and timer chip.
//
// Input channel (in_valid/in_ready): one item per handshake, either a bus
// read, a bus write, or new levels on the port A or port B input pins.
// Result channel (out_valid/out_ready): exactly one result item per input
// item, in order: read data, IRQ line, both pin vectors and notify bits,
// all showing the register state after the item.
//
// Timing: the edge that accepts an item writes its result into the output
// register, or into the skid register while the output is held. Throughput:
// one item per clock while in_ready is high; the decode, byte muxes and the
// 16-bit timer 2 decrement all sit between the input ports and the state/result registers.
//
// A two-entry result buffer (output register plus skid register) decouples
// the channels: in_ready stays high while one result waits, and drops only
// when both entries are full, so a stall on the result side stops intake
// after one extra item and nothing is lost.
//
// Reset (rst_n low, synchronous) clears the result buffer and returns all
// registers to power-on values: counters and T2 low latch all ones, rest zero.
module parallel_io_timer_register_file (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [3:0] in_reg_index,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic [7:0] out_port_a_pins,
  output logic [7:0] out_port_b_pins,
  output logic       out_port_a_notify,
  output logic       out_port_b_notify
);

  // Architectural state
  logic [7:0]  out_latch_a_r, out_latch_a_nxt;
  logic [7:0]  out_latch_b_r, out_latch_b_nxt;
  logic [7:0]  dir_mask_a_r, dir_mask_a_nxt;
  logic [7:0]  dir_mask_b_r, dir_mask_b_nxt;
  logic [7:0]  in_pins_a_r, in_pins_a_nxt;
  logic [7:0]  in_pins_b_r, in_pins_b_nxt;
  logic [7:0]  t1_latch_lo_r, t1_latch_lo_nxt;
  logic [7:0]  t1_latch_hi_r, t1_latch_hi_nxt;
  logic [15:0] t1_count_r, t1_count_nxt;
  logic [15:0] t2_count_r, t2_count_nxt;
  logic [7:0]  t2_latch_lo_r, t2_latch_lo_nxt;
  logic        t2_running_r, t2_running_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [7:0]  aux_ctrl_r, aux_ctrl_nxt;
  logic [7:0]  periph_ctrl_r, periph_ctrl_nxt;
  logic [6:0]  irq_flags_r, irq_flags_nxt;
  logic [6:0]  irq_enables_r, irq_enables_nxt;
  logic [7:0]  no_hs_a_r, no_hs_a_nxt;

  // Result buffer
  logic                out_v_r, out_v_nxt;
  logic                skid_v_r, skid_v_nxt;
  piotrf_pkg::res_t    out_r, out_nxt;
  piotrf_pkg::res_t    skid_r, skid_nxt;
  piotrf_pkg::res_t    res;

  logic        push;
  logic        pop;
  logic [7:0]  pins_a_cur, pins_b_cur;
  logic [7:0]  pins_a_new, pins_b_new;
  logic        irq_cur;
  logic [15:0] t2_dec;

  assign in_ready = !skid_v_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_v_r && out_ready;

  assign pins_a_cur = (in_pins_a_r & ~dir_mask_a_r) | (out_latch_a_r & dir_mask_a_r);
  assign pins_b_cur = (in_pins_b_r & ~dir_mask_b_r) | (out_latch_b_r & dir_mask_b_r);
  assign pins_a_new = (in_pins_a_nxt & ~dir_mask_a_nxt) | (out_latch_a_nxt & dir_mask_a_nxt);
  assign pins_b_new = (in_pins_b_nxt & ~dir_mask_b_nxt) | (out_latch_b_nxt & dir_mask_b_nxt);
  assign irq_cur    = |(irq_flags_r & irq_enables_r);
  assign t2_dec     = t2_count_r - 16'd1;

  // Item decode: next state and the result of this item
  always_comb begin
    out_latch_a_nxt = out_latch_a_r;
    out_latch_b_nxt = out_latch_b_r;
    dir_mask_a_nxt  = dir_mask_a_r;
    dir_mask_b_nxt  = dir_mask_b_r;
    in_pins_a_nxt   = in_pins_a_r;
    in_pins_b_nxt   = in_pins_b_r;
    t1_latch_lo_nxt = t1_latch_lo_r;
    t1_latch_hi_nxt = t1_latch_hi_r;
    t1_count_nxt    = t1_count_r;
    t2_count_nxt    = t2_count_r;
    t2_latch_lo_nxt = t2_latch_lo_r;
    t2_running_nxt  = t2_running_r;
    shift_byte_nxt  = shift_byte_r;
    aux_ctrl_nxt    = aux_ctrl_r;
    periph_ctrl_nxt = periph_ctrl_r;
    irq_flags_nxt   = irq_flags_r;
    irq_enables_nxt = irq_enables_r;
    no_hs_a_nxt     = no_hs_a_r;
    res.read_data   = 8'd0;
    res.port_b_notify = 1'b0;

    case (in_mode)
      piotrf_pkg::MODE_READ: begin
        case (in_reg_index)
          piotrf_pkg::REG_ORB:  res.read_data = pins_b_cur;
          piotrf_pkg::REG_ORA:  res.read_data = pins_a_cur;
          piotrf_pkg::REG_DDRB: res.read_data = dir_mask_b_r;
          piotrf_pkg::REG_DDRA: res.read_data = dir_mask_a_r;
          piotrf_pkg::REG_T1CL: begin
            res.read_data = t1_count_r[7:0];
            irq_flags_nxt = irq_flags_r & ~piotrf_pkg::FLAG_T1;
          end
          piotrf_pkg::REG_T1CH: res.read_data = t1_count_r[15:8];
          piotrf_pkg::REG_T1LL: res.read_data = t1_latch_lo_r;
          piotrf_pkg::REG_T1LH: res.read_data = t1_latch_hi_r;
          piotrf_pkg::REG_T2CL: begin
            res.read_data = t2_count_r[7:0];
            irq_flags_nxt = irq_flags_r & ~piotrf_pkg::FLAG_T2;
          end
          piotrf_pkg::REG_T2CH: res.read_data = t2_count_r[15:8];
          piotrf_pkg::REG_SR: begin
            res.read_data = shift_byte_r;
            irq_flags_nxt = irq_flags_r & ~piotrf_pkg::FLAG_SR;
          end
          piotrf_pkg::REG_ACR: res.read_data = aux_ctrl_r;
          piotrf_pkg::REG_PCR: res.read_data = periph_ctrl_r;
          piotrf_pkg::REG_IFR: res.read_data = {irq_cur, irq_flags_r};
          piotrf_pkg::REG_IER: res.read_data = {1'b1, irq_enables_r};
          default:             res.read_data = no_hs_a_r;
        endcase
      end
      piotrf_pkg::MODE_WRITE: begin
        case (in_reg_index)
          piotrf_pkg::REG_ORB:  out_latch_b_nxt = in_write_data;
          piotrf_pkg::REG_ORA:  out_latch_a_nxt = in_write_data;
          piotrf_pkg::REG_DDRB: dir_mask_b_nxt  = in_write_data;
          piotrf_pkg::REG_DDRA: dir_mask_a_nxt  = in_write_data;
          piotrf_pkg::REG_T1CL: t1_latch_lo_nxt = in_write_data;
          piotrf_pkg::REG_T1CH: begin
            // T1 load: counter takes the full latch, PB7 forced low in PB7 mode if PB7 is an output
            t1_latch_hi_nxt = in_write_data;
            t1_count_nxt    = {in_write_data, t1_latch_lo_r};
            irq_flags_nxt   = irq_flags_r & ~piotrf_pkg::FLAG_T1;
            if (aux_ctrl_r[piotrf_pkg::ACR_PB7_BIT] && dir_mask_b_r[7]) begin
              out_latch_b_nxt   = {1'b0, out_latch_b_r[6:0]};
              res.port_b_notify = 1'b1;
            end
          end
          piotrf_pkg::REG_T1LL: t1_latch_lo_nxt = in_write_data;
          piotrf_pkg::REG_T1LH: begin
            t1_latch_hi_nxt = in_write_data;
            irq_flags_nxt   = irq_flags_r & ~piotrf_pkg::FLAG_T1;
          end
          piotrf_pkg::REG_T2CL: t2_latch_lo_nxt = in_write_data;
          piotrf_pkg::REG_T2CH: begin
            t2_count_nxt   = {in_write_data, t2_latch_lo_r};
            irq_flags_nxt  = irq_flags_r & ~piotrf_pkg::FLAG_T2;
            t2_running_nxt = 1'b1;
          end
          piotrf_pkg::REG_SR: begin
            shift_byte_nxt = in_write_data;
            irq_flags_nxt  = irq_flags_r & ~piotrf_pkg::FLAG_SR;
          end
          piotrf_pkg::REG_ACR: aux_ctrl_nxt    = in_write_data;
          piotrf_pkg::REG_PCR: periph_ctrl_nxt = in_write_data;
          piotrf_pkg::REG_IFR: irq_flags_nxt   = irq_flags_r & ~in_write_data[6:0];
          piotrf_pkg::REG_IER: begin
            if (in_write_data[7]) begin
              irq_enables_nxt = irq_enables_r | in_write_data[6:0];
            end else begin
              irq_enables_nxt = irq_enables_r & ~in_write_data[6:0];
            end
          end
          default: begin
            no_hs_a_nxt     = in_write_data;
            out_latch_a_nxt = in_write_data;
          end
        endcase
      end
      piotrf_pkg::MODE_PINSA: in_pins_a_nxt = in_write_data;
      default: begin
        // Pulse counting: falling edge on PB6 input decrements timer 2
        if (aux_ctrl_r[piotrf_pkg::ACR_PULSE_BIT] && t2_running_r &&
            in_pins_b_r[6] && !in_write_data[6]) begin
          t2_count_nxt = t2_dec;
          if (t2_dec == piotrf_pkg::COUNT_ALL_ONES) begin
            irq_flags_nxt  = irq_flags_r | piotrf_pkg::FLAG_T2;
            t2_running_nxt = 1'b0;
          end
        end
        in_pins_b_nxt = in_write_data;
      end
    endcase

    res.irq         = |(irq_flags_nxt & irq_enables_nxt);
    res.port_a_pins = pins_a_new;
    res.port_b_pins = pins_b_new;
    res.port_a_notify = (in_mode == piotrf_pkg::MODE_WRITE) &&
                        ((in_reg_index == piotrf_pkg::REG_ORA) ||
                         (in_reg_index == piotrf_pkg::REG_DDRA)) &&
                        (pins_a_new != pins_a_cur);
    if ((in_mode == piotrf_pkg::MODE_WRITE) &&
        ((in_reg_index == piotrf_pkg::REG_ORB) ||
         (in_reg_index == piotrf_pkg::REG_DDRB)) &&
        (pins_b_new != pins_b_cur)) begin
      res.port_b_notify = 1'b1;
    end
  end

  // Two-entry result buffer
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (out_v_r && !pop) begin
      if (push) begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (skid_v_r) begin
      out_nxt    = skid_r;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      out_nxt   = res;
      out_v_nxt = 1'b1;
    end else begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_latch_a_r <= 8'd0;
      out_latch_b_r <= 8'd0;
      dir_mask_a_r  <= 8'd0;
      dir_mask_b_r  <= 8'd0;
      in_pins_a_r   <= 8'd0;
      in_pins_b_r   <= 8'd0;
      t1_latch_lo_r <= 8'd0;
      t1_latch_hi_r <= 8'd0;
      t1_count_r    <= piotrf_pkg::COUNT_ALL_ONES;
      t2_count_r    <= piotrf_pkg::COUNT_ALL_ONES;
      t2_latch_lo_r <= 8'hFF;
      t2_running_r  <= 1'b0;
      shift_byte_r  <= 8'd0;
      aux_ctrl_r    <= 8'd0;
      periph_ctrl_r <= 8'd0;
      irq_flags_r   <= 7'd0;
      irq_enables_r <= 7'd0;
      no_hs_a_r     <= 8'd0;
    end else if (push) begin
      out_latch_a_r <= out_latch_a_nxt;
      out_latch_b_r <= out_latch_b_nxt;
      dir_mask_a_r  <= dir_mask_a_nxt;
      dir_mask_b_r  <= dir_mask_b_nxt;
      in_pins_a_r   <= in_pins_a_nxt;
      in_pins_b_r   <= in_pins_b_nxt;
      t1_latch_lo_r <= t1_latch_lo_nxt;
      t1_latch_hi_r <= t1_latch_hi_nxt;
      t1_count_r    <= t1_count_nxt;
      t2_count_r    <= t2_count_nxt;
      t2_latch_lo_r <= t2_latch_lo_nxt;
      t2_running_r  <= t2_running_nxt;
      shift_byte_r  <= shift_byte_nxt;
      aux_ctrl_r    <= aux_ctrl_nxt;
      periph_ctrl_r <= periph_ctrl_nxt;
      irq_flags_r   <= irq_flags_nxt;
      irq_enables_r <= irq_enables_nxt;
      no_hs_a_r     <= no_hs_a_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_read_data     = out_r.read_data;
  assign out_irq           = out_r.irq;
  assign out_port_a_pins   = out_r.port_a_pins;
  assign out_port_b_pins   = out_r.port_b_pins;
  assign out_port_a_notify = out_r.port_a_notify;
  assign out_port_b_notify = out_r.port_b_notify;

endmodule
